FILE: src/nsf_pkg.sv
// nsf_pkg: shared constants, types and helpers of the nmea sentence framer.
// Used by nsf_ctrl, nsf_dpath and nmea_sentence_framer; depends on nothing.
`timescale 1ns / 1ps

package nsf_pkg;

   // default sizes of the address and payload stores
   localparam int DEF_ADDR_MAX    = 8;
   localparam int DEF_PAYLOAD_MAX = 64;

   // framing characters
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // known sentence addresses
   localparam int NAME_LEN = 5;
   localparam logic [0:NAME_LEN-1][7:0] NAME_GGA = {8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
   localparam logic [0:NAME_LEN-1][7:0] NAME_VTG = {8'h47, 8'h50, 8'h56, 8'h54, 8'h47};

   // sentence kind codes
   localparam logic [1:0] KIND_GGA   = 2'd0;
   localparam logic [1:0] KIND_VTG   = 2'd1;
   localparam logic [1:0] KIND_OTHER = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic begin_sentence;  // clear checksum and index
      logic addr_wr;         // store an address character
      logic addr_close;      // separator: latch address length
      logic data_wr;         // store a payload character
      logic data_close;      // latch payload length
      logic hex_hi;          // take the high checksum digit
      logic start_emit;      // bump count, latch kind, rewind read index
      logic fetch;           // read the payload store
      logic load;            // fill the result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_dollar;
      logic is_sep;
      logic is_star;
      logic is_cr;
      logic addr_full;
      logic data_full;
      logic check_ok;
      logic last_item;
      logic out_free;
   } status_type;

   // ascii hex digit decode with 8-bit wrap
   function automatic logic [7:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      if (b <= CHAR_NINE) begin
         v = b - 8'd48;
      end else begin
         v = b - 8'd55;
      end
      return v;
   endfunction

endpackage

FILE: src/nsf_ctrl.sv
// nsf_ctrl: sentence framing state machine, drives datapath commands.
// Depends on nsf_pkg for the command and status structs.
`timescale 1ns / 1ps

module nsf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nsf_pkg::status_type status,
   output nsf_pkg::cmd_type    cmd
);
   import nsf_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_ADDR,
      ST_DATA,
      ST_HEX1,
      ST_HEX2,
      ST_FETCH,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      accept;

   assign accept    = req_valid && !stall_ff;
   assign req_stall = stall_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_HUNT: begin
            if (accept && status.is_dollar) begin
               cmd.begin_sentence = 1'b1;
               state_in           = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (accept) begin
               if (status.is_sep) begin
                  cmd.addr_close = 1'b1;
                  state_in       = ST_DATA;
               end else begin
                  cmd.addr_wr = 1'b1;
                  if (status.addr_full) begin
                     state_in = ST_HUNT;
                  end
               end
            end
         end
         ST_DATA: begin
            if (accept) begin
               if (status.is_star) begin
                  cmd.data_close = 1'b1;
                  state_in       = ST_HEX1;
               end else if (status.is_cr) begin
                  cmd.data_close = 1'b1;
                  cmd.start_emit = 1'b1;
                  state_in       = ST_FETCH;
               end else begin
                  cmd.data_wr = 1'b1;
                  if (status.data_full) begin
                     state_in = ST_HUNT;
                  end
               end
            end
         end
         ST_HEX1: begin
            if (accept) begin
               cmd.hex_hi = 1'b1;
               state_in   = ST_HEX2;
            end
         end
         ST_HEX2: begin
            if (accept) begin
               if (status.check_ok) begin
                  cmd.start_emit = 1'b1;
                  state_in       = ST_FETCH;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = status.last_item ? ST_HUNT : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // input is held off while a payload drains
   always_comb begin
      stall_in = (state_in == ST_FETCH) || (state_in == ST_LOAD);
   end

   // state and registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

endmodule

FILE: src/nsf_dpath.sv
// nsf_dpath: address and payload stores, checksum, counters and result register.
// Depends on nsf_pkg; commanded by nsf_ctrl.
`timescale 1ns / 1ps

module nsf_dpath #(
   parameter int ADDR_MAX    = nsf_pkg::DEF_ADDR_MAX,
   parameter int PAYLOAD_MAX = nsf_pkg::DEF_PAYLOAD_MAX
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_rx_byte,
   input  nsf_pkg::cmd_type    cmd,
   output nsf_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_sentence_kind,
   output logic [7:0]          rsp_payload_byte,
   output logic                rsp_payload_valid,
   output logic                rsp_last_byte,
   output logic [15:0]         rsp_sentence_count
);
   import nsf_pkg::*;

   localparam int AD_W = $clog2(ADDR_MAX);
   localparam int PL_W = $clog2(PAYLOAD_MAX);
   localparam int WI_W = (AD_W > PL_W) ? AD_W : PL_W;

   logic [WI_W-1:0] wi_ff, wi_in;
   logic [7:0]      check_ff, check_in;
   logic [7:0]      recv_ff;
   logic [AD_W-1:0] addr_len_ff;
   logic [PL_W-1:0] data_len_ff;
   logic [PL_W-1:0] rd_idx_ff;
   logic [7:0]      rd_data_ff;
   logic [15:0]     count_ff;
   logic [1:0]      kind_ff, kind_in;
   logic [7:0]      addr_store_ff [ADDR_MAX];
   logic [7:0]      payload_mem [PAYLOAD_MAX];
   logic [7:0]      hex_now;
   logic            data_empty;
   logic            is_gga, is_vtg;

   logic            out_valid_ff;
   logic [1:0]      out_kind_ff;
   logic [7:0]      out_byte_ff;
   logic            out_pvalid_ff;
   logic            out_last_ff;
   logic [15:0]     out_count_ff;

   // byte classification and checksum test
   assign hex_now    = hex_value(req_rx_byte);
   assign data_empty = (data_len_ff == '0);

   always_comb begin
      status.is_dollar = (req_rx_byte == CHAR_DOLLAR);
      status.is_star   = (req_rx_byte == CHAR_STAR);
      status.is_sep    = (req_rx_byte == CHAR_COMMA) || (req_rx_byte == CHAR_STAR);
      status.is_cr     = (req_rx_byte == CHAR_CR);
      status.addr_full = (wi_ff == WI_W'(ADDR_MAX - 1));
      status.data_full = (wi_ff == WI_W'(PAYLOAD_MAX - 1));
      status.check_ok  = ((recv_ff | hex_now) == check_ff);
      status.last_item = data_empty || (rd_idx_ff == (data_len_ff - 1'b1));
      status.out_free  = !out_valid_ff || !rsp_stall;
   end

   // write index and running checksum
   always_comb begin
      wi_in    = wi_ff;
      check_in = check_ff;
      if (cmd.begin_sentence || cmd.addr_close) begin
         wi_in = '0;
      end else if (cmd.addr_wr || cmd.data_wr) begin
         wi_in = wi_ff + 1'b1;
      end
      if (cmd.begin_sentence) begin
         check_in = '0;
      end else if (cmd.addr_wr || cmd.addr_close || cmd.data_wr) begin
         check_in = check_ff ^ req_rx_byte;
      end
   end

   // address match against the known names
   always_comb begin
      is_gga = (addr_len_ff == AD_W'(NAME_LEN));
      is_vtg = (addr_len_ff == AD_W'(NAME_LEN));
      for (int i = 0; i < NAME_LEN; i++) begin
         if (addr_store_ff[i] != NAME_GGA[i]) begin
            is_gga = 1'b0;
         end
         if (addr_store_ff[i] != NAME_VTG[i]) begin
            is_vtg = 1'b0;
         end
      end
      if (is_gga) begin
         kind_in = KIND_GGA;
      end else if (is_vtg) begin
         kind_in = KIND_VTG;
      end else begin
         kind_in = KIND_OTHER;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wi_ff       <= '0;
         check_ff    <= '0;
         recv_ff     <= '0;
         addr_len_ff <= '0;
         data_len_ff <= '0;
         rd_idx_ff   <= '0;
         count_ff    <= '0;
         kind_ff     <= KIND_OTHER;
      end else begin
         wi_ff    <= wi_in;
         check_ff <= check_in;
         if (cmd.hex_hi) begin
            recv_ff <= {hex_now[3:0], 4'h0};
         end
         if (cmd.addr_close) begin
            addr_len_ff <= wi_ff[AD_W-1:0];
         end
         if (cmd.data_close) begin
            data_len_ff <= wi_ff[PL_W-1:0];
         end
         if (cmd.start_emit) begin
            rd_idx_ff <= '0;
            count_ff  <= count_ff + 16'd1;
            kind_ff   <= kind_in;
         end else if (cmd.load) begin
            rd_idx_ff <= rd_idx_ff + 1'b1;
         end
      end
   end

   // address store
   always_ff @(posedge clock) begin
      if (cmd.addr_wr) begin
         addr_store_ff[wi_ff[AD_W-1:0]] <= req_rx_byte;
      end
   end

   // payload memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.data_wr) begin
         payload_mem[wi_ff[PL_W-1:0]] <= req_rx_byte;
      end
      if (cmd.fetch) begin
         rd_data_ff <= payload_mem[rd_idx_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_kind_ff   <= kind_ff;
         out_byte_ff   <= data_empty ? 8'h00 : rd_data_ff;
         out_pvalid_ff <= !data_empty;
         out_last_ff   <= status.last_item;
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_sentence_kind  = out_kind_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_payload_valid  = out_pvalid_ff;
   assign rsp_last_byte      = out_last_ff;
   assign rsp_sentence_count = out_count_ff;

endmodule

FILE: src/nmea_sentence_framer.sv
// nmea_sentence_framer: frames '$'-started sentences, checks the xor checksum
// and emits each accepted payload as a tagged run of bytes.
// Parse phase takes one request per cycle; an accepted sentence drains its
// payload byte by byte: each is read from the registered payload memory, then
// loaded into the result register when free; requests stall during the drain.
// Synchronous active-high reset returns to hunting and clears count and result valid.
`timescale 1ns / 1ps

module nmea_sentence_framer #(
   parameter int ADDR_MAX    = nsf_pkg::DEF_ADDR_MAX,
   parameter int PAYLOAD_MAX = nsf_pkg::DEF_PAYLOAD_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_sentence_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_payload_valid,
   output logic        rsp_last_byte,
   output logic [15:0] rsp_sentence_count
);
   import nsf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // framing controller
   nsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, checksum and result register
   nsf_dpath #(
      .ADDR_MAX    (ADDR_MAX),
      .PAYLOAD_MAX (PAYLOAD_MAX)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sentence_kind  (rsp_sentence_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_sentence_count (rsp_sentence_count)
   );

endmodule
